// ===== hdl/i2cms_pkg.sv =====
// Shared types and constants for the I2C master bit sequencer.
package i2cms_pkg;

	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_SACK  = 3'd4,
		CMD_RACK  = 3'd5
	} cmd_t;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [7:0] SETTLE_RESET = 8'd5;

	// extra hold delays on top of the settle time
	localparam logic [2:0] EXTRA_NONE  = 3'd0;
	localparam logic [2:0] EXTRA_SHORT = 3'd2;
	localparam logic [2:0] EXTRA_SAMP  = 3'd3;
	localparam logic [2:0] EXTRA_LONG  = 3'd5;

	// index of the final segment of each run
	localparam logic [4:0] LAST_START = 5'd3;
	localparam logic [4:0] LAST_STOP  = 5'd2;
	localparam logic [4:0] LAST_WRITE = 5'd31;
	localparam logic [4:0] LAST_READ  = 5'd24;
	localparam logic [4:0] LAST_ACK   = 5'd3;

	typedef struct packed {
		cmd_t       cmd;
		logic [4:0] last_step;
		logic [7:0] tx_data;
		logic       ack_bit;
		logic [7:0] bus_levels;
	} item_t;

endpackage

// ===== hdl/i2cms_front.sv =====
// Front end: accepts commands, drops unused codes, tags run length.
module i2cms_front (
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [2:0]         cmd,
	input  logic [7:0]         tx_data,
	input  logic               ack_bit,
	input  logic [7:0]         bus_levels,
	input  logic               q_full,
	output logic               q_push,
	output i2cms_pkg::item_t   q_item
);
	import i2cms_pkg::*;

	logic       known;
	logic [4:0] last_step;

	always_comb begin
		known     = 1'b1;
		last_step = LAST_START;
		case (cmd)
			CMD_START: last_step = LAST_START;
			CMD_STOP:  last_step = LAST_STOP;
			CMD_WRITE: last_step = LAST_WRITE;
			CMD_READ:  last_step = LAST_READ;
			CMD_SACK, CMD_RACK: last_step = LAST_ACK;
			default:   known = 1'b0;
		endcase
	end

	assign cmd_stall = q_full;
	// unused codes are taken and vanish
	assign q_push    = cmd_valid && !q_full && known;

	assign q_item.cmd        = cmd_t'(cmd);
	assign q_item.last_step  = last_step;
	assign q_item.tx_data    = tx_data;
	assign q_item.ack_bit    = ack_bit;
	assign q_item.bus_levels = bus_levels;
endmodule

// ===== hdl/i2cms_queue.sv =====
// Small command queue between front end and sequencer.
module i2cms_queue #(
	parameter int unsigned DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  i2cms_pkg::item_t   push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output i2cms_pkg::item_t   head_item
);
	import i2cms_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ===== hdl/i2cms_back.sv =====
// Sequencer: expands the head command into line segments, one per cycle unless stalled.
module i2cms_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         settle_us,
	input  logic               head_valid,
	input  i2cms_pkg::item_t   head_item,
	output logic               pop,
	output logic               seg_valid,
	input  logic               seg_stall,
	output logic               scl_level,
	output logic               sda_drive,
	output logic [8:0]         hold_us,
	output logic               sample_point,
	output logic [7:0]         rx_byte,
	output logic               rx_ack,
	output logic               last
);
	import i2cms_pkg::*;

	logic [4:0] step_q;
	logic [1:0] phase_q;
	logic [2:0] bit_q;
	logic       scl_q, sda_q;
	logic       seg_valid_q;

	logic       emit, is_last, wrap;
	logic       scl_n, sda_n, samp;
	logic [2:0] extra;

	assign emit    = head_valid && (!seg_valid_q || !seg_stall);
	assign is_last = (step_q == head_item.last_step);
	assign pop     = emit && is_last;
	assign wrap    = (head_item.cmd == CMD_WRITE) ? (phase_q == 2'd3) : (phase_q == 2'd2);

	always_comb begin
		scl_n = scl_q;
		sda_n = sda_q;
		samp  = 1'b0;
		extra = EXTRA_SHORT;
		case (head_item.cmd)
			CMD_START: begin
				extra = EXTRA_LONG;
				case (step_q)
					5'd0:    sda_n = 1'b1;
					5'd1:    scl_n = 1'b1;
					5'd2:    sda_n = 1'b0;
					default: scl_n = 1'b0;
				endcase
			end
			CMD_STOP: begin
				extra = EXTRA_LONG;
				case (step_q)
					5'd0:    sda_n = 1'b0;
					5'd1:    scl_n = 1'b1;
					default: sda_n = 1'b1;
				endcase
			end
			CMD_WRITE: begin
				case (phase_q)
					2'd0: scl_n = 1'b0;
					2'd1: sda_n = head_item.tx_data[~bit_q];
					2'd2: begin
						scl_n = 1'b1;
						extra = EXTRA_LONG;
					end
					default: scl_n = 1'b0;
				endcase
			end
			CMD_READ: begin
				if (step_q == '0) begin
					sda_n = 1'b1;
					extra = EXTRA_NONE;
				end else begin
					case (phase_q)
						2'd0: scl_n = 1'b0;
						2'd1: scl_n = 1'b1;
						default: begin
							samp  = 1'b1;
							extra = EXTRA_SAMP;
						end
					endcase
				end
			end
			CMD_SACK: begin
				case (step_q)
					5'd0: scl_n = 1'b0;
					5'd1: sda_n = head_item.ack_bit;
					5'd2: begin
						scl_n = 1'b1;
						extra = EXTRA_LONG;
					end
					default: scl_n = 1'b0;
				endcase
			end
			CMD_RACK: begin
				case (step_q)
					5'd0: sda_n = 1'b1;
					5'd1: begin
						scl_n = 1'b1;
						extra = EXTRA_LONG;
					end
					5'd2: begin
						samp  = 1'b1;
						extra = EXTRA_NONE;
					end
					default: scl_n = 1'b0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			phase_q     <= '0;
			bit_q       <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			seg_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				scl_q       <= scl_n;
				sda_q       <= sda_n;
				seg_valid_q <= 1'b1;
				if (is_last) begin
					step_q  <= '0;
					phase_q <= '0;
					bit_q   <= '0;
				end else begin
					step_q <= step_q + 1'b1;
					// read byte has one lead-in segment before its bit phases
					if (!(head_item.cmd == CMD_READ && step_q == '0)) begin
						if (wrap) begin
							phase_q <= '0;
							bit_q   <= bit_q + 1'b1;
						end else begin
							phase_q <= phase_q + 1'b1;
						end
					end
				end
			end else if (!seg_stall) begin
				seg_valid_q <= 1'b0;
			end
		end
	end

	// output payload, loaded with each beat
	always_ff @(posedge clk) begin
		if (emit) begin
			scl_level    <= scl_n;
			sda_drive    <= sda_n;
			hold_us      <= {1'b0, settle_us} + {6'd0, extra};
			sample_point <= samp;
			rx_byte      <= (is_last && head_item.cmd == CMD_READ) ?
			                head_item.bus_levels : 8'd0;
			rx_ack       <= is_last && head_item.cmd == CMD_RACK && head_item.bus_levels[7];
			last         <= is_last;
		end
	end

	assign seg_valid = seg_valid_q;
endmodule

// ===== hdl/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer top level: front end, command queue, segment sequencer.
// Each accepted command expands into a run of line segments delivered one beat per
// cycle unless stalled: start 4, stop 3, write byte 32, read byte 25, send ack 4,
// receive ack 4 segments; codes 6 and 7 are accepted and produce nothing. The
// sequencer, which emits one segment per clock unless stalled, sets the rate; a
// small command queue lets new commands be accepted while a run is still being
// emitted. A stalled beat holds the sequencer in place until it is taken. Line
// levels reset to released. settle_us resets to 5 and is written through the cfg
// port (always ready) by the user only while idle; the block does not enforce it.
module i2c_master_bit_sequencer #(
	parameter int unsigned QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [2:0] cmd,
	input  logic [7:0] tx_data,
	input  logic       ack_bit,
	input  logic [7:0] bus_levels,
	output logic       seg_valid,
	input  logic       seg_stall,
	output logic       scl_level,
	output logic       sda_drive,
	output logic [8:0] hold_us,
	output logic       sample_point,
	output logic [7:0] rx_byte,
	output logic       rx_ack,
	output logic       last
);
	import i2cms_pkg::*;

	logic [7:0] settle_q;
	logic       q_full, q_push, q_pop, head_valid;
	item_t      push_item, head_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) settle_q <= SETTLE_RESET;
		else if (cfg_valid) settle_q <= cfg_data;
	end

	i2cms_front u_front (
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.tx_data    (tx_data),
		.ack_bit    (ack_bit),
		.bus_levels (bus_levels),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	i2cms_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	i2cms_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.settle_us    (settle_q),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (q_pop),
		.seg_valid    (seg_valid),
		.seg_stall    (seg_stall),
		.scl_level    (scl_level),
		.sda_drive    (sda_drive),
		.hold_us      (hold_us),
		.sample_point (sample_point),
		.rx_byte      (rx_byte),
		.rx_ack       (rx_ack),
		.last         (last)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("command queue overflow");

	a_rx_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && !last) |-> (rx_byte == 8'd0 && !rx_ack))
		else $error("receive data outside final segment");

	a_sample_scl_high: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_valid && sample_point) |-> scl_level)
		else $error("sample taken with SCL low");

	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> head_valid) else $error("queue pop while empty");
endmodule
